[design/bmet_pkg.sv]
// ----------------------------------------------------------------------------
// bmet_pkg
// Types and constants shared by the brewer current monitor modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bmet_pkg;

	// request function codes
	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// message codes
	localparam logic [1:0] MSG_NONE    = 2'd0;
	localparam logic [1:0] MSG_STARTED = 2'd1;
	localparam logic [1:0] MSG_BREW    = 2'd2;
	localparam logic [1:0] MSG_AGE     = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_SMOOTHING = 2'd1;
	localparam logic [1:0] REG_STALE     = 2'd2;

	// reset values of the configuration registers
	localparam logic [7:0]  THRESHOLD_RST = 8'd128;
	localparam logic [8:0]  SMOOTHING_RST = 9'd51;
	localparam logic [15:0] STALE_RST     = 16'd5400;

	localparam logic [8:0]  SMOOTHING_MAX = 9'd256;
	localparam logic [15:0] SECONDS_MAX   = 16'hFFFF;
	localparam logic [5:0]  SEC_PER_MIN_LAST = 6'd59;
	localparam logic [10:0] MINUTES_MAX   = 11'd1092;

	typedef struct packed {
		logic       func;
		logic [7:0] sample;
	} req_t;

	typedef struct packed {
		logic [1:0]  message;
		logic [10:0] age_minutes;
		logic [7:0]  filtered_level;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  threshold;
		logic [15:0] stale_limit;
	} ctrl_cfg_t;

endpackage

[design/bmet_ema.sv]
// ----------------------------------------------------------------------------
// bmet_ema
// Moving average update: avg + floor(alpha * (x - avg) / 256).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmet_ema (
	input  logic [7:0] sample,
	input  logic [7:0] level,
	input  logic [8:0] smoothing,
	output logic [7:0] level_next
);

	logic [8:0]         alpha;
	logic signed [9:0]  alpha_s;
	logic signed [8:0]  diff_s;
	logic signed [18:0] prod_s;
	logic signed [10:0] sum_s;

	// (a*x + (256-a)*avg) >> 8 folded into a single signed product
	always_comb begin
		alpha   = (smoothing > bmet_pkg::SMOOTHING_MAX) ? bmet_pkg::SMOOTHING_MAX : smoothing;
		alpha_s = signed'({1'b0, alpha});
		diff_s  = signed'({1'b0, sample}) - signed'({1'b0, level});
		prod_s  = alpha_s * diff_s;
		sum_s   = signed'({3'b000, level}) + prod_s[18:8];
		level_next = sum_s[7:0];
	end

endmodule

[design/bmet_ctrl.sv]
// ----------------------------------------------------------------------------
// bmet_ctrl
// Brewing / age state machine, age counters and message selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bmet_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  func,
	input  logic [7:0]            level_next,
	input  bmet_pkg::ctrl_cfg_t   cfg,
	output logic [7:0]            level,
	output bmet_pkg::rsp_t        result
);

	logic [7:0]  level_q;
	logic        brewing_q;
	logic        fresh_q;
	logic        running_q;
	logic [15:0] sec_q;
	logic [10:0] min_q;
	logic [5:0]  rem_q;

	logic [7:0]  level_d;
	logic        brewing_d;
	logic        fresh_d;
	logic        running_d;
	logic [15:0] sec_d;
	logic [10:0] min_d;
	logic [5:0]  rem_d;

	// minutes are kept alongside seconds so no divide is needed
	always_comb begin
		level_d   = level_q;
		brewing_d = brewing_q;
		fresh_d   = fresh_q;
		running_d = running_q;
		sec_d     = sec_q;
		min_d     = min_q;
		rem_d     = rem_q;
		result.message     = bmet_pkg::MSG_NONE;
		result.age_minutes = '0;
		case (func)
			bmet_pkg::FUNC_TICK: begin
				if (running_q && sec_q != bmet_pkg::SECONDS_MAX) begin
					sec_d = sec_q + 16'd1;
					if (rem_q == bmet_pkg::SEC_PER_MIN_LAST) begin
						rem_d = '0;
						min_d = min_q + 11'd1;
					end else begin
						rem_d = rem_q + 6'd1;
					end
				end
			end
			bmet_pkg::FUNC_SAMPLE: begin
				level_d = level_next;
				if (level_next > cfg.threshold) begin
					if (!brewing_q) begin
						brewing_d = 1'b1;
						fresh_d   = 1'b1;
						result.message = bmet_pkg::MSG_STARTED;
					end
				end else begin
					if (fresh_q) begin
						sec_d     = '0;
						min_d     = '0;
						rem_d     = '0;
						running_d = 1'b1;
						fresh_d   = 1'b0;
					end
					if (brewing_q && sec_d > cfg.stale_limit) begin
						running_d = 1'b0;
						brewing_d = 1'b0;
						result.message = bmet_pkg::MSG_BREW;
					end else if (brewing_q) begin
						result.message     = bmet_pkg::MSG_AGE;
						result.age_minutes = min_d;
					end
				end
			end
			default: begin
			end
		endcase
		result.filtered_level = level_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			brewing_q <= 1'b0;
			fresh_q   <= 1'b0;
			running_q <= 1'b0;
			sec_q     <= '0;
			min_q     <= '0;
			rem_q     <= '0;
		end else if (step) begin
			level_q   <= level_d;
			brewing_q <= brewing_d;
			fresh_q   <= fresh_d;
			running_q <= running_d;
			sec_q     <= sec_d;
			min_q     <= min_d;
			rem_q     <= rem_d;
		end
	end

	assign level = level_q;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= bmet_pkg::SEC_PER_MIN_LAST)
		else $error("seconds-in-minute counter out of range");

	a_min_range: assert property (@(posedge clk) disable iff (!arst_n)
		min_q <= bmet_pkg::MINUTES_MAX)
		else $error("minute counter beyond saturated age");

	a_fresh_brewing: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> brewing_q)
		else $error("fresh flag set outside a brew");

	a_sec_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(sec_q == bmet_pkg::SECONDS_MAX && !fresh_q) |=> sec_q == bmet_pkg::SECONDS_MAX)
		else $error("saturated age counter moved");

endmodule

[design/brew_monitor_ema_threshold.sv]
// ----------------------------------------------------------------------------
// brew_monitor_ema_threshold
// Brewer supply current monitor: moving average, brew state and coffee age.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one request: func 1 is
//   a current sample, func 0 a one-second tick.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one response
//   per request, in order: message code, age in minutes, filtered level.
//   cfg channel writes threshold (0), smoothing (1), stale limit (2); it is
//   always ready and should be used only while no request is in flight.
//   Path: input register, then response register; rsp_valid rises as the
//   request enters the response register, once any held response is taken.
//   Throughput: one request per cycle while rsp_ready is high; the whole
//   update is one pass through the average multiplier and compare logic.
//   A stalled rsp_ready holds the response register; one more request can
//   sit in the input register, after which req_ready drops.
//   Reset clears the average, flags and age counters and loads the default
//   configuration; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brew_monitor_ema_threshold (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bmet_pkg::req_t   req_data,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output bmet_pkg::rsp_t   rsp_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	logic [7:0]          threshold_q;
	logic [8:0]          smoothing_q;
	logic [15:0]         stale_q;
	bmet_pkg::ctrl_cfg_t ctrl_cfg;

	bmet_pkg::req_t req_s1;
	logic           req_valid_s1;
	bmet_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic           advance;
	logic [7:0]     level;
	logic [7:0]     level_next;
	bmet_pkg::rsp_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= bmet_pkg::THRESHOLD_RST;
			smoothing_q <= bmet_pkg::SMOOTHING_RST;
			stale_q     <= bmet_pkg::STALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				bmet_pkg::REG_THRESHOLD: threshold_q <= cfg_data[7:0];
				bmet_pkg::REG_SMOOTHING: smoothing_q <= cfg_data[8:0];
				bmet_pkg::REG_STALE:     stale_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign ctrl_cfg.threshold   = threshold_q;
	assign ctrl_cfg.stale_limit = stale_q;

	// item moves from input register to response register
	assign advance   = req_valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !req_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_ready) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req_data;
		end
	end

	bmet_ema u_ema (
		.sample     (req_s1.sample),
		.level      (level),
		.smoothing  (smoothing_q),
		.level_next (level_next)
	);

	bmet_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.func       (req_s1.func),
		.level_next (level_next),
		.cfg        (ctrl_cfg),
		.level      (level),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[tb/tb_brew_monitor_ema_threshold.sv]
// ----------------------------------------------------------------------------
// tb_brew_monitor_ema_threshold
// Self-checking bench for the brewer current monitor. A scoreboard class
// tracks the moving average, the brew flags and the coffee age counter.
// It predicts one response per accepted request and compares the responses
// in order. Directed requests come first. Then come phases of brew cycles
// under changing thresholds, smoothing factors and stale limits, with random
// idle bursts on both channels. A quiet tail checks minute rollover and the
// stale limit at its edges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_brew_monitor_ema_threshold;

	localparam int          CLK_PERIOD  = 10;
	localparam int          DRAIN_PAD   = 4;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned SEC_PER_MIN = 60;
	localparam int unsigned MAX_REPORTS = 10;

	class brew_scoreboard;
		logic [7:0]      threshold;
		logic [8:0]      alpha;
		logic [15:0]     stale_limit;
		logic [7:0]      level;
		bit              brewing;
		bit              fresh;
		bit              age_on;
		logic [15:0]     age_sec;
		bmet_pkg::rsp_t  expected_rsp_q[$];
		int unsigned     mismatches;
		int unsigned     checked;
		int unsigned     msg_seen[4];

		function new();
			threshold   = bmet_pkg::THRESHOLD_RST;
			alpha       = bmet_pkg::SMOOTHING_RST;
			stale_limit = bmet_pkg::STALE_RST;
			level       = '0;
			brewing     = 1'b0;
			fresh       = 1'b0;
			age_on      = 1'b0;
			age_sec     = '0;
			mismatches  = 0;
			checked     = 0;
			foreach (msg_seen[i])
				msg_seen[i] = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				bmet_pkg::REG_THRESHOLD: threshold = data[7:0];
				bmet_pkg::REG_SMOOTHING: alpha = data[8:0];
				bmet_pkg::REG_STALE:     stale_limit = data;
				default: ;
			endcase
		endfunction

		// advance the brew state for one request and queue its response
		function void note_request(bmet_pkg::req_t r);
			bmet_pkg::rsp_t e;
			int unsigned    a;
			int unsigned    acc;
			e = '0;
			if (r.func == bmet_pkg::FUNC_TICK) begin
				if (age_on && age_sec != bmet_pkg::SECONDS_MAX)
					age_sec++;
			end else begin
				a = 32'((alpha > bmet_pkg::SMOOTHING_MAX) ? bmet_pkg::SMOOTHING_MAX : alpha);
				acc = a * r.sample + (256 - a) * level;
				level = 8'(acc >> 8);
				if (level > threshold) begin
					if (!brewing) begin
						brewing = 1'b1;
						fresh = 1'b1;
						e.message = bmet_pkg::MSG_STARTED;
					end
				end else begin
					// first quiet sample after a brew starts the age clock
					if (fresh) begin
						age_sec = '0;
						age_on = 1'b1;
						fresh = 1'b0;
					end
					if (brewing && age_sec > stale_limit) begin
						age_on = 1'b0;
						brewing = 1'b0;
						e.message = bmet_pkg::MSG_BREW;
					end else if (brewing) begin
						e.message = bmet_pkg::MSG_AGE;
						e.age_minutes = 11'(age_sec / SEC_PER_MIN);
					end
				end
			end
			e.filtered_level = level;
			expected_rsp_q.push_back(e);
		endfunction

		function void check_response(bmet_pkg::rsp_t got);
			bmet_pkg::rsp_t want;
			checked++;
			if (expected_rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("ERROR: response with no request pending: msg=%0d age=%0d level=%0d",
						got.message, got.age_minutes, got.filtered_level);
				return;
			end
			want = expected_rsp_q.pop_front();
			msg_seen[got.message]++;
			if (got.message !== want.message || got.age_minutes !== want.age_minutes ||
					got.filtered_level !== want.filtered_level) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("ERROR: response %0d: expected msg=%0d age=%0d level=%0d",
						checked, want.message, want.age_minutes, want.filtered_level);
					$display("       got msg=%0d age=%0d level=%0d",
						got.message, got.age_minutes, got.filtered_level);
				end
			end
		endfunction

		function void close_out();
			if (expected_rsp_q.size() != 0) begin
				$display("ERROR: %0d responses never arrived", expected_rsp_q.size());
				mismatches += expected_rsp_q.size();
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_ready;
	bmet_pkg::req_t  req_data;
	logic            rsp_valid;
	logic            rsp_ready;
	bmet_pkg::rsp_t  rsp_data;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [1:0]      cfg_index;
	logic [15:0]     cfg_data;

	brew_scoreboard sb = new();
	bit             allow_idle;
	int unsigned    req_idle_pct;
	int unsigned    rsp_idle_pct;
	int unsigned    n_sent;
	int unsigned    n_ticks;
	int unsigned    cycle_count;

	brew_monitor_ema_threshold i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	// keeps req_valid high on return so back-to-back requests need no toggle
	task automatic send_item(logic func, logic [7:0] sample);
		bmet_pkg::req_t r;
		r.func = func;
		r.sample = sample;
		if ((n_sent % 64) == 0)
			req_idle_pct = pick_idle_pct();
		if (allow_idle && $urandom_range(0, 99) < req_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		do @(posedge clk); while (!req_ready);
		sb.note_request(r);
		n_sent++;
		if (func == bmet_pkg::FUNC_TICK)
			n_ticks++;
	endtask

	task automatic wait_all_answered();
		req_valid <= 1'b0;
		while (sb.expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// junk in the unused upper bits of cfg_data must be dropped
	task automatic load_config(logic [7:0] thr, logic [8:0] alpha, logic [15:0] stale);
		logic [15:0] vals[3];
		logic [1:0]  idx[3];
		logic [7:0]  thr_junk;
		logic [6:0]  alpha_junk;
		thr_junk = 8'($urandom);
		alpha_junk = 7'($urandom);
		vals[0] = {thr_junk, thr};
		vals[1] = {alpha_junk, alpha};
		vals[2] = stale;
		idx[0] = bmet_pkg::REG_THRESHOLD;
		idx[1] = bmet_pkg::REG_SMOOTHING;
		idx[2] = bmet_pkg::REG_STALE;
		cfg_valid <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	// a random run of hot samples with the odd tick, then runs of ticks between quiet samples
	task automatic brew_cycle(logic [7:0] thr);
		int unsigned hot_n;
		int unsigned cool_n;
		logic [7:0]  hot_floor;
		hot_floor = (thr == 8'hFF) ? thr : thr + 8'd1;
		hot_n = $urandom_range(1, 12);
		repeat (hot_n) begin
			if ($urandom_range(0, 3) == 0)
				send_item(bmet_pkg::FUNC_TICK, 8'($urandom));
			send_item(bmet_pkg::FUNC_SAMPLE, 8'($urandom_range(255, hot_floor)));
		end
		cool_n = $urandom_range(2, 8);
		repeat (cool_n) begin
			repeat ($urandom_range(0, 40)) send_item(bmet_pkg::FUNC_TICK, 8'($urandom));
			send_item(bmet_pkg::FUNC_SAMPLE, 8'($urandom_range(0, thr)));
		end
	endtask

	task automatic brew_phase(logic [7:0] thr, logic [8:0] alpha, logic [15:0] stale,
			int unsigned n_items);
		int unsigned stop_at;
		wait_all_answered();
		load_config(thr, alpha, stale);
		stop_at = n_sent + n_items;
		while (n_sent < stop_at) begin
			if ($urandom_range(0, 9) < 8)
				brew_cycle(thr);
			else
				repeat ($urandom_range(1, 8)) send_item(1'($urandom), 8'($urandom));
		end
	endtask

	task automatic directed_items();
		// reset defaults: the average needs four full-scale samples to trip
		send_item(bmet_pkg::FUNC_TICK, 8'hFF);
		repeat (4) send_item(bmet_pkg::FUNC_SAMPLE, 8'hFF);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'h00);
		repeat (2) send_item(bmet_pkg::FUNC_TICK, 8'h00);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'h00);
		wait_all_answered();
		load_config(8'd128, bmet_pkg::SMOOTHING_MAX, 16'd3);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'hFF);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'd128);	// level equal to threshold counts as off
		repeat (2) send_item(bmet_pkg::FUNC_TICK, 8'hA5);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'd0);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'd129);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'd128);
		wait_all_answered();
		// smoothing above full scale acts as full scale
		load_config(8'd0, 9'h1FF, 16'd0);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'd1);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'd0);
		send_item(bmet_pkg::FUNC_TICK, 8'h5A);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'd0);
		wait_all_answered();
		load_config(8'hFF, 9'd0, 16'hFFFF);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'hFF);
		send_item(bmet_pkg::FUNC_TICK, 8'h00);
	endtask

	task automatic age_edges();
		wait_all_answered();
		// stale limit zero ends the brew at the first quiet sample after a tick
		load_config(8'd100, bmet_pkg::SMOOTHING_MAX, 16'd0);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'hFF);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'h00);
		send_item(bmet_pkg::FUNC_TICK, 8'h00);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'h00);
		wait_all_answered();
		// a couple of minute rollovers under the largest stale limit
		load_config(8'd100, bmet_pkg::SMOOTHING_MAX, bmet_pkg::SECONDS_MAX);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'hFF);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'h00);
		repeat (130) send_item(bmet_pkg::FUNC_TICK, 8'($urandom));
		send_item(bmet_pkg::FUNC_SAMPLE, 8'h00);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'hFF);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'h00);
		wait_all_answered();
		load_config(8'd100, bmet_pkg::SMOOTHING_MAX, bmet_pkg::SECONDS_MAX - 16'd1);
		send_item(bmet_pkg::FUNC_SAMPLE, 8'h00);
	endtask

	initial begin : rsp_side
		int unsigned stall_left;
		int unsigned span;
		stall_left = 0;
		span = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				sb.check_response(rsp_data);
			if (span == 0) begin
				span = 64;
				rsp_idle_pct = pick_idle_pct();
			end
			span--;
			if (stall_left == 0 && allow_idle && $urandom_range(0, 99) < rsp_idle_pct)
				stall_left = $urandom_range(1, 19);
			if (stall_left != 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: timeout after %0d cycles", cycle_count);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = bmet_pkg::REG_THRESHOLD;
		cfg_data = '0;
		allow_idle = 1'b0;
		n_sent = 0;
		n_ticks = 0;
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		allow_idle = 1'b1;

		directed_items();
		brew_phase(8'($urandom_range(60, 200)), bmet_pkg::SMOOTHING_RST,
			bmet_pkg::STALE_RST, 90);
		brew_phase(8'd0, bmet_pkg::SMOOTHING_MAX, 16'd0, 90);
		brew_phase(8'hFF, 9'($urandom_range(1, 255)), 16'($urandom_range(0, 200)), 50);
		brew_phase(8'($urandom_range(0, 254)), 9'($urandom_range(1, 255)),
			16'($urandom_range(0, 200)), 190);
		brew_phase(8'($urandom_range(0, 254)), 9'($urandom_range(257, 511)),
			16'($urandom_range(0, 200)), 130);
		brew_phase(8'($urandom_range(0, 254)), 9'd0, 16'($urandom_range(0, 200)), 40);
		brew_phase(8'($urandom_range(0, 254)), 9'($urandom_range(1, 256)), 16'hFFFF, 90);

		// tail runs with no idling on either side
		wait_all_answered();
		allow_idle = 1'b0;
		age_edges();
		brew_phase(8'($urandom_range(0, 254)), 9'($urandom_range(1, 256)),
			16'($urandom_range(0, 300)), 130);
		wait_all_answered();
		sb.close_out();

		$display("Drove %0d requests (%0d ticks), checked %0d responses in %0d cycles.",
			n_sent, n_ticks, sb.checked, cycle_count);
		$display("Responses seen: %0d brew started, %0d brew new, %0d age shown, %0d quiet.",
			sb.msg_seen[bmet_pkg::MSG_STARTED], sb.msg_seen[bmet_pkg::MSG_BREW],
			sb.msg_seen[bmet_pkg::MSG_AGE], sb.msg_seen[bmet_pkg::MSG_NONE]);
		if (sb.mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
